// File: sv/kpr_pkg.sv
`timescale 1ns / 1ps
// Package for the k-th present entry removal unit: field widths, command
// and status codes, state encoding and the structs between top and tree walker.
// No dependencies.
package kpr_pkg;

  localparam int MaxItemsDefault = 1024;

  localparam int CmdW    = 2;
  localparam int ValueW  = 32;
  localparam int RankW   = 11;
  localparam int IndexW  = 10;
  localparam int StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } kpr_cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RANK = 2'd1,
    STATUS_FULL     = 2'd2
  } kpr_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_DONE
  } kpr_state_e;

  // Request to the tree walker: start a root-to-leaf pass, removal or append
  typedef struct packed {
    logic start;
    logic remove;
  } kpr_walk_ctrl_t;

  // Walker status: busy while it steps through the tree levels, done on the last level
  typedef struct packed {
    logic busy;
    logic done;
  } kpr_walk_stat_t;

endpackage

// File: sv/kpr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and result words.
// Depends on kpr_pkg for the field widths.
interface kpr_in_if;
  import kpr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic signed [ValueW-1:0] item_value;
  logic [RankW-1:0]         rank;

  modport source (output valid, output command, output item_value, output rank,
                  input ready);
  modport sink (input valid, input command, input item_value, input rank,
                output ready);
endinterface

interface kpr_out_if;
  import kpr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] removed_value;
  logic [IndexW-1:0]        removed_index;
  logic [StatusW-1:0]       status;

  modport source (output valid, output removed_value, output removed_index,
                  output status, input ready);
  modport sink (input valid, input removed_value, input removed_index,
                input status, output ready);
endinterface

// File: sv/kpr_walk.sv
`timescale 1ns / 1ps
// Presence count tree walker: a memory of left-subtree counts, one entry per
// internal node, walked root to leaf one level per cycle. Depends on kpr_pkg.
module kpr_walk #(
  parameter int MaxItems = kpr_pkg::MaxItemsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kpr_pkg::kpr_walk_ctrl_t              ctrl_i,
  input  logic [$clog2(MaxItems+1)-1:0]        rank_i,
  input  logic [$clog2(MaxItems+1)-1:0]        fill_i,
  output kpr_pkg::kpr_walk_stat_t              stat_o,
  output logic [$clog2(MaxItems)-1:0]          slot_o
);
  import kpr_pkg::*;

  localparam int Levels = $clog2(MaxItems);
  localparam int Nodes  = 2 ** Levels;
  localparam int CntW   = Levels;
  localparam int FillW  = $clog2(MaxItems + 1);
  localparam int DepW   = (Levels > 1) ? $clog2(Levels) : 1;

  // Left-subtree count per internal node; entry 0 is unused
  logic [CntW-1:0]   cnt_mem [Nodes];
  logic [CntW-1:0]   rd_data_q;
  logic [Levels-1:0] rd_addr;
  logic              wr_en;
  logic [Levels-1:0] wr_addr;
  logic [CntW-1:0]   wr_data;

  logic              busy_q, busy_d;
  logic              remove_q, remove_d;
  logic [DepW-1:0]   depth_q, depth_d;
  logic [Levels-1:0] path_q, path_d;
  logic [FillW-1:0]  k_q, k_d;

  logic              last;
  logic [Levels-1:0] cur_node;
  logic [Levels-1:0] sub_lo;
  logic [Levels-1:0] fill_shift;
  logic [CntW-1:0]   left_cnt;
  logic              go_left;

  // Entry is current only if its left subtree holds an appended slot
  always_comb begin
    last       = (depth_q == DepW'(Levels - 1));
    cur_node   = (Levels'(1) << depth_q) | path_q;
    sub_lo     = path_q << (Levels - int'(depth_q));
    fill_shift = fill_i[Levels-1:0] << depth_q;
    left_cnt   = (FillW'(sub_lo) < fill_i) ? rd_data_q : '0;
    go_left    = remove_q ? (k_q <= FillW'(left_cnt)) : ~fill_shift[Levels-1];
  end

  // Step one level: pick a child, fix the left count, fetch the next node
  always_comb begin
    busy_d   = busy_q;
    remove_d = remove_q;
    depth_d  = depth_q;
    path_d   = path_q;
    k_d      = k_q;
    wr_en    = 1'b0;
    wr_addr  = cur_node;
    wr_data  = remove_q ? (left_cnt - CntW'(1)) : (left_cnt + CntW'(1));
    rd_addr  = Levels'(1);
    stat_o   = '0;
    slot_o   = Levels'({path_q, ~go_left});
    if (busy_q) begin
      stat_o.busy = 1'b1;
      wr_en       = go_left;
      path_d      = Levels'({path_q, ~go_left});
      if (!go_left) begin
        k_d = k_q - FillW'(left_cnt);
      end
      if (last) begin
        busy_d      = 1'b0;
        stat_o.done = 1'b1;
      end else begin
        depth_d = depth_q + DepW'(1);
        rd_addr = (Levels'(1) << (int'(depth_q) + 1)) | path_d;
      end
    end else if (ctrl_i.start) begin
      busy_d   = 1'b1;
      remove_d = ctrl_i.remove;
      depth_d  = '0;
      path_d   = '0;
      k_d      = rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remove_q <= remove_d;
    depth_q  <= depth_d;
    path_q   <= path_d;
    k_q      <= k_d;
  end

  // Count memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= cnt_mem[rd_addr];
  end

endmodule

// File: sv/kth_present_removal_unit.sv
`timescale 1ns / 1ps
// Top level of the k-th present entry removal unit: command sequencer,
// value store, fill count and result register. Depends on kpr_pkg, kpr_if, kpr_walk.
//
// Usage:
//   in_i carries one command word: append item_value, remove the entry of
//   1-based rank among those still present, or clear the list. out_o returns
//   exactly one result word per command (value, slot index, status).
//   Commands are taken one at a time. An append or a removal walks the count
//   tree one level per cycle, log2(MaxItems) levels (10 at 1024 entries),
//   then hands its result to the result register from S_FETCH (removal) or
//   S_DONE (append) before the next command is accepted. Clear, out-of-range
//   ranks, loads into a full list and unknown commands skip the walk and go
//   straight to S_DONE.
//   The result register lets the next command be accepted while a result
//   waits on out_o; if the receiver stalls, the following result holds in
//   the sequencer until the register frees.
//   Reset and clear take effect at once with no memory sweep: tree entries
//   whose slots lie at or beyond the fill count read as zero.
module kth_present_removal_unit #(
  parameter int MaxItems = kpr_pkg::MaxItemsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kpr_in_if.sink     in_i,
  kpr_out_if.source  out_o
);
  import kpr_pkg::*;

  localparam int Levels = $clog2(MaxItems);
  localparam int FillW  = $clog2(MaxItems + 1);

  kpr_state_e state_q, state_d;

  logic [FillW-1:0]   loaded_q, loaded_d;
  logic [FillW-1:0]   total_q, total_d;
  logic               remove_q, remove_d;
  logic [Levels-1:0]  slot_q, slot_d;
  logic [IndexW-1:0]  res_index_q, res_index_d;
  kpr_status_e        res_status_q, res_status_d;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q;
  logic [IndexW-1:0]        out_index_q;
  logic [StatusW-1:0]       out_status_q;
  logic                     out_load;

  logic [ValueW-1:0] val_mem [MaxItems];
  logic [ValueW-1:0] val_rd_q;
  logic [Levels-1:0] val_raddr;
  logic              val_we;

  kpr_walk_ctrl_t    walk_ctrl;
  kpr_walk_stat_t    walk_stat;
  logic [Levels-1:0] walk_slot;

  kpr_walk #(
    .MaxItems(MaxItems)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (walk_ctrl),
    .rank_i (FillW'(in_i.rank)),
    .fill_i (loaded_q),
    .stat_o (walk_stat),
    .slot_o (walk_slot)
  );

  // Sequence one command: decode, walk, fetch the value, hand off the result
  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    total_d      = total_q;
    remove_d     = remove_q;
    slot_d       = slot_q;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    walk_ctrl    = '0;
    val_we       = 1'b0;
    out_load     = 1'b0;
    in_i.ready   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          res_index_d  = '0;
          res_status_d = STATUS_OK;
          state_d      = S_DONE;
          unique case (kpr_cmd_e'(in_i.command))
            CMD_APPEND: begin
              if (loaded_q >= FillW'(MaxItems)) begin
                res_status_d = STATUS_FULL;
              end else begin
                val_we           = 1'b1;
                walk_ctrl.start  = 1'b1;
                walk_ctrl.remove = 1'b0;
                remove_d         = 1'b0;
                state_d          = S_WALK;
              end
            end
            CMD_REMOVE: begin
              if (in_i.rank == '0 || int'(in_i.rank) > int'(total_q)) begin
                res_status_d = STATUS_BAD_RANK;
              end else begin
                walk_ctrl.start  = 1'b1;
                walk_ctrl.remove = 1'b1;
                remove_d         = 1'b1;
                state_d          = S_WALK;
              end
            end
            CMD_CLEAR: begin
              loaded_d = '0;
              total_d  = '0;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_stat.done) begin
          if (remove_q) begin
            total_d     = total_q - FillW'(1);
            slot_d      = walk_slot;
            res_index_d = IndexW'(walk_slot);
            state_d     = S_FETCH;
          end else begin
            loaded_d = loaded_q + FillW'(1);
            total_d  = total_q + FillW'(1);
            state_d  = S_DONE;
          end
        end
      end
      S_FETCH, S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remove_q     <= remove_d;
    slot_q       <= slot_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
  end

  // Value store: append writes the next slot, removal reads the found slot
  assign val_raddr = (state_q == S_WALK) ? walk_slot : slot_q;

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[loaded_q[Levels-1:0]] <= in_i.item_value;
    end
    val_rd_q <= val_mem[val_raddr];
  end

  // Result register: load when free or being taken, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= (state_q == S_FETCH) ? val_rd_q : '0;
      out_index_q  <= res_index_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = out_value_q;
  assign out_o.removed_index = out_index_q;
  assign out_o.status        = out_status_q;

  // Present entries never outnumber appended slots
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= loaded_q)
    else $error("present count exceeds fill count");

  // The walker runs exactly while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_WALK) == walk_stat.busy)
    else $error("walker and sequencer out of step");

  // A new result only comes from a finished command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result load did not return to idle");

  // A removal that walked the tree always frees one present entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_WALK && walk_stat.done && remove_q)
                   |=> total_q == $past(total_q) - FillW'(1))
    else $error("removal did not drop the present count");

endmodule

// File: sim/tb_kth_present_removal_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for kth_present_removal_unit: directed table, then random
// append/remove/clear episodes checked against a slot-list predictor.
// Depends on kpr_pkg, kpr_if and the unit itself.
module tb_kth_present_removal_unit;
  import kpr_pkg::*;

  localparam int MaxSlots    = MaxItemsDefault;
  localparam int TotalWords  = 1900;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int ScriptRows  = 25;

  // Command code with no meaning; the unit answers it with an all-zero word
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
    kpr_status_e              status;
  } result_t;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [ValueW-1:0] value;
    logic [RankW-1:0]         rank;
    bit                       typed;
    result_t                  want;
  } script_row_t;

  localparam result_t Zeros   = '{'0, '0, STATUS_OK};
  localparam result_t BadRank = '{'0, '0, STATUS_BAD_RANK};

  // Directed table; rows with typed clear take their answer from the predictor
  script_row_t script [ScriptRows] = '{
    '{CMD_REMOVE, 32'h0000_0000, 11'd1,    1'b1, BadRank},
    '{CMD_REMOVE, 32'h0000_0000, 11'd0,    1'b1, BadRank},
    '{CMD_APPEND, 32'h8000_0000, 11'd2047, 1'b1, Zeros},
    '{CMD_APPEND, 32'h7FFF_FFFF, 11'd0,    1'b1, Zeros},
    '{CMD_APPEND, 32'h0000_0000, 11'd1,    1'b1, Zeros},
    '{CMD_APPEND, 32'hFFFF_FFFF, 11'd1024, 1'b1, Zeros},
    '{CMD_APPEND, 32'h5555_AAAA, 11'd3,    1'b1, Zeros},
    '{CMD_REMOVE, 32'h0000_0000, 11'd0,    1'b1, BadRank},
    '{CMD_REMOVE, 32'h0000_0000, 11'd6,    1'b1, BadRank},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 11'd2047, 1'b1, BadRank},
    '{CMD_REMOVE, 32'h0000_0000, 11'd5,    1'b1, '{32'h5555_AAAA, 10'd4, STATUS_OK}},
    '{CMD_REMOVE, 32'h0000_0000, 11'd1,    1'b1, '{32'h8000_0000, 10'd0, STATUS_OK}},
    '{CMD_REMOVE, 32'h1357_9BDF, 11'd2,    1'b0, Zeros},
    '{CmdUnused,  32'hFFFF_FFFF, 11'd2047, 1'b1, Zeros},
    '{CMD_REMOVE, 32'h0000_0000, 11'd3,    1'b1, BadRank},
    '{CMD_REMOVE, 32'h0000_0000, 11'd2,    1'b0, Zeros},
    '{CMD_APPEND, 32'h1234_5678, 11'd0,    1'b1, Zeros},
    '{CMD_REMOVE, 32'h0000_0000, 11'd2,    1'b0, Zeros},
    '{CMD_CLEAR,  32'hFFFF_FFFF, 11'd2047, 1'b1, Zeros},
    '{CMD_REMOVE, 32'h0000_0000, 11'd1,    1'b1, BadRank},
    '{CMD_APPEND, 32'hDEAD_BEEF, 11'd0,    1'b1, Zeros},
    '{CMD_REMOVE, 32'h0000_0000, 11'd1,    1'b1, '{32'hDEAD_BEEF, 10'd0, STATUS_OK}},
    '{CMD_REMOVE, 32'h0000_0000, 11'd1,    1'b1, BadRank},
    '{CMD_CLEAR,  32'h0000_0000, 11'd0,    1'b1, Zeros},
    '{CMD_APPEND, 32'h0000_0001, 11'd0,    1'b1, Zeros}
  };

  logic clk_i;
  logic rst_ni;

  kpr_in_if  cmd_if ();
  kpr_out_if res_if ();

  kth_present_removal_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Predictor state: slot values, live marks, fill and live counts
  logic signed [ValueW-1:0] slot_value [MaxSlots];
  bit                       slot_live  [MaxSlots];
  int                       fill_count;
  int                       live_count;

  result_t pending_results [$];
  int      fails;
  int      words_sent;
  int      words_checked;
  int      n_removed, n_bad_rank, n_full, n_clear;
  bit      quiet;
  int      hold_left;

  // Advance the slot list by one command word and return its result word
  function automatic result_t list_step(logic [CmdW-1:0] cmd,
                                        logic signed [ValueW-1:0] value,
                                        logic [RankW-1:0] rank);
    result_t res;
    int      seen;
    res  = Zeros;
    seen = 0;
    case (cmd)
      CMD_APPEND: begin
        if (fill_count >= MaxSlots) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          slot_value[fill_count] = value;
          slot_live[fill_count]  = 1'b1;
          fill_count++;
          live_count++;
        end
      end
      CMD_REMOVE: begin
        if (rank == 0 || rank > live_count) begin
          res.status = STATUS_BAD_RANK;
          n_bad_rank++;
        end else begin
          // Walk the slots in order, counting live ones up to the rank
          for (int s = 0; s < MaxSlots; s++) begin
            if (slot_live[s]) begin
              seen++;
              if (seen == rank) begin
                slot_live[s] = 1'b0;
                live_count--;
                res.value = slot_value[s];
                res.index = IndexW'(s);
                break;
              end
            end
          end
          n_removed++;
        end
      end
      CMD_CLEAR: begin
        fill_count = 0;
        live_count = 0;
        foreach (slot_live[s]) slot_live[s] = 1'b0;
        n_clear++;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one command word, hold it until taken, then record its expectation
  task automatic send_word(input logic [CmdW-1:0] cmd,
                           input logic signed [ValueW-1:0] value,
                           input logic [RankW-1:0] rank,
                           input bit typed,
                           input result_t want);
    int      gap;
    result_t got;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.item_value <= value;
    cmd_if.rank       <= rank;
    do @(posedge clk_i); while (!cmd_if.ready);
    got = list_step(cmd, value, rank);
    pending_results.insert(pending_results.size(), typed ? want : got);
    if (cmd != CmdUnused) words_sent++;
  endtask

  // Remove with a rank that is in range when anything is live
  task automatic remove_live();
    int pick;
    pick = $urandom_range(0, 3);
    if (live_count == 0)
      send_word(CMD_REMOVE, $urandom, RankW'($urandom), 1'b0, Zeros);
    else if (pick == 0)
      send_word(CMD_REMOVE, $urandom, RankW'(1), 1'b0, Zeros);
    else if (pick == 1)
      send_word(CMD_REMOVE, $urandom, RankW'(live_count), 1'b0, Zeros);
    else
      send_word(CMD_REMOVE, $urandom, RankW'($urandom_range(1, live_count)), 1'b0,
                Zeros);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop on a hung handshake
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("kth_present_removal_unit verification failed");
    $finish;
  end

  // Result side: random backpressure, quiet episodes run without stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      hold_left    <= pick_gap();
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no command pending");
        fails++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (res_if.removed_value !== want.value) begin
          $error("removed_value: expected %0d, got %0d", want.value, res_if.removed_value);
          fails++;
        end
        if (res_if.removed_index !== want.index) begin
          $error("removed_index: expected %0d, got %0d", want.index, res_if.removed_index);
          fails++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          fails++;
        end
      end
    end
  end

  initial begin
    int episode;
    int ops;
    int r;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_APPEND;
    cmd_if.item_value <= '0;
    cmd_if.rank       <= '0;
    quiet             = 1'b0;
    words_sent        = 0;
    fill_count        = 0;
    live_count        = 0;
    foreach (slot_live[s]) slot_live[s] = 1'b0;
    episode           = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (script[i])
      send_word(script[i].cmd, script[i].value, script[i].rank, script[i].typed,
                script[i].want);

    // Random episodes; the third one fills the list to the last slot
    while (words_sent < TotalWords) begin
      episode++;
      quiet = ($urandom_range(0, 5) == 0);
      if (episode == 3) begin
        send_word(CMD_CLEAR, $urandom, RankW'($urandom), 1'b0, Zeros);
        while (fill_count < MaxSlots) begin
          if ($urandom_range(0, 9) == 0) remove_live();
          else send_word(CMD_APPEND, $urandom, RankW'($urandom), 1'b0, Zeros);
        end
        repeat (3) send_word(CMD_APPEND, $urandom, RankW'($urandom), 1'b0, Zeros);
        send_word(CMD_REMOVE, $urandom, RankW'(live_count), 1'b0, Zeros);
        send_word(CMD_REMOVE, $urandom, RankW'(1), 1'b0, Zeros);
        send_word(CMD_REMOVE, $urandom, RankW'(live_count + 1), 1'b0, Zeros);
      end else begin
        if ($urandom_range(0, 2) != 0)
          send_word(CMD_CLEAR, $urandom, RankW'($urandom), 1'b0, Zeros);
        ops = $urandom_range(10, 60);
        repeat (ops) begin
          r = $urandom_range(0, 99);
          if (r < 45)
            send_word(CMD_APPEND, $urandom, RankW'($urandom), 1'b0, Zeros);
          else if (r < 85)
            remove_live();
          else if (r < 90)
            send_word(CMD_REMOVE, $urandom, RankW'(0), 1'b0, Zeros);
          else if (r < 95)
            send_word(CMD_REMOVE, $urandom,
                      RankW'($urandom_range(live_count + 1, 2047)), 1'b0, Zeros);
          else if (r < 98)
            send_word(CMD_CLEAR, $urandom, RankW'($urandom), 1'b0, Zeros);
          else
            send_word(CmdUnused, $urandom, RankW'($urandom), 1'b0, Zeros);
        end
      end
    end
    cmd_if.valid <= 1'b0;

    // Drain outstanding results, then let the unit settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d command words in %0d episodes, %0d result words checked.",
             words_sent, episode, words_checked);
    $display("Seen: %0d removals, %0d out-of-range ranks, %0d refused appends, %0d clears.",
             n_removed, n_bad_rank, n_full, n_clear);
    if (fails == 0) begin
      $display("kth_present_removal_unit verification clean");
    end else begin
      $display("kth_present_removal_unit verification failed");
    end
    $finish;
  end

endmodule
